>>> hdl/wrr_pkg.sv
`timescale 1ns / 1ps

package wrr_pkg;

   localparam int MAX_PARTICLES = 1024;
   localparam int WEIGHT_BITS   = 16;
   localparam int VALUE_BITS    = 16;
   localparam int R_BITS        = 16;
   localparam int INDEX_BITS    = $clog2(MAX_PARTICLES);
   localparam int COUNT_BITS    = INDEX_BITS + 1;
   localparam int SUM_BITS      = WEIGHT_BITS + INDEX_BITS;
   localparam int PROD_BITS     = R_BITS + SUM_BITS;
   localparam int LEVELS        = INDEX_BITS;
   localparam int LEVEL_BITS    = $clog2(INDEX_BITS + 1);

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_DRAW = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [VALUE_BITS-1:0] value;
      logic                  first;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] chosen_index;
      logic                  uniform_fallback;
      logic                  empty_error;
   } rsp_type;

   // One draw as it walks down the search chain
   typedef struct packed {
      logic                  valid;
      logic [INDEX_BITS-1:0] pos;
      logic [SUM_BITS-1:0]   thresh;
      logic [COUNT_BITS-1:0] count;
      logic                  empty;
      logic                  fallback;
   } stage_type;

endpackage

>>> hdl/wrr_ram.sv
`timescale 1ns / 1ps

module wrr_ram #(
   parameter int ADDR_BITS = 1,
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/wrr_cell.sv
`timescale 1ns / 1ps

module wrr_cell import wrr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [LEVEL_BITS-1:0] level,
   input  stage_type             up,
   output stage_type             down,
   output logic [INDEX_BITS-1:0] ram_addr,
   input  logic [SUM_BITS-1:0]   ram_rdata
);

   stage_type             hold_ff, hold_in;
   stage_type             down_ff, down_in;
   logic [INDEX_BITS-1:0] bit_mask;
   logic [INDEX_BITS-1:0] probe;
   logic                  take;

   // This level stores every index whose trailing-ones count equals level
   assign ram_addr = up.pos >> (level + LEVEL_BITS'(1));
   assign hold_in  = up;

   always_comb begin
      bit_mask = INDEX_BITS'(1) << level;
      probe    = hold_ff.pos | (bit_mask - INDEX_BITS'(1));
      take     = ({1'b0, probe} < hold_ff.count) && (ram_rdata <= hold_ff.thresh);
      down_in  = hold_ff;
      if (take) begin
         down_in.pos = hold_ff.pos | bit_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff.valid <= 1'b0;
         down_ff.valid <= 1'b0;
      end else begin
         hold_ff <= hold_in;
         down_ff <= down_in;
      end
   end

   assign down = down_ff;

endmodule

>>> hdl/weighted_roulette_resampler_top.sv
`timescale 1ns / 1ps

// Weighted roulette resampler.
// req channel: one item per weight load (func 0, first restarts the set at
// index zero) or per draw (func 1, value is a Q0.16 uniform fraction).
// rsp channel: one item per draw: chosen index, uniform fallback flag and
// empty error flag. Loads give no result.
// Loads are taken one per cycle while req_ready is high. A draw is scaled by
// one multiplier, then walks a chain of ten search cells, one per index bit,
// each cell owning the prefix sums probed at its level and doing a registered
// memory read, then a registered compare. The result is registered into the
// rsp slot, and the next item can be taken in the cycle it appears on rsp.
// While a draw is in the chain no item is taken.
// Reset (synchronous, active high) empties the weight set and both result
// slots; the prefix memories are not cleared and need no clearing pass.
// A stalled receiver holds the result on rsp; one more draw can finish into
// a second slot, after which req_ready stays low until rsp drains.

module weighted_roulette_resampler_top import wrr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic [SUM_BITS-1:0]   total_ff, total_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   stage_type             stage0_ff, stage0_in;
   rsp_type               out_ff, out_in, skid_ff, skid_in;
   logic                  out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic                  req_fire, load_fire, draw_fire, rsp_fire;
   logic [SUM_BITS-1:0]   base_total, new_total, mult_operand;
   logic [COUNT_BITS-1:0] base_count;
   logic                  wr_en;
   logic [INDEX_BITS-1:0] wr_index;
   logic [LEVEL_BITS-1:0] wr_level;
   logic [PROD_BITS-1:0]  product;

   stage_type             chain [0:LEVELS];
   logic [INDEX_BITS-1:0] rd_addr [0:LEVELS-1];
   logic [SUM_BITS-1:0]   rd_data [0:LEVELS-1];

   stage_type             last;
   logic                  arrive;
   logic [COUNT_BITS-1:0] count_m1;
   rsp_type               result;

   assign req_ready = !busy_ff && !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && (req_payload.func == FUNC_LOAD);
   assign draw_fire = req_fire && (req_payload.func == FUNC_DRAW);
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Load path: append one weight while below capacity, restarting the set when first is set
   always_comb begin
      base_total = req_payload.first ? '0 : total_ff;
      base_count = req_payload.first ? '0 : count_ff;
      new_total  = base_total + SUM_BITS'(req_payload.value[WEIGHT_BITS-1:0]);
      wr_en      = load_fire && (base_count < COUNT_BITS'(MAX_PARTICLES));
      wr_index   = base_count[INDEX_BITS-1:0];
      total_in   = total_ff;
      count_in   = count_ff;
      if (wr_en) begin
         total_in = new_total;
         count_in = base_count + COUNT_BITS'(1);
      end else if (load_fire && req_payload.first) begin
         total_in = '0;
         count_in = '0;
      end
   end

   // Level of an index is its count of trailing ones
   always_comb begin
      wr_level = LEVEL_BITS'(INDEX_BITS);
      for (int i = INDEX_BITS - 1; i >= 0; i--) begin
         if (!wr_index[i]) begin
            wr_level = LEVEL_BITS'(i);
         end
      end
   end

   // Draw entry: one shared multiply gives the threshold or the uniform index
   always_comb begin
      mult_operand     = (total_ff == '0) ? SUM_BITS'(count_ff) : total_ff;
      product          = PROD_BITS'(req_payload.value) * PROD_BITS'(mult_operand);
      stage0_in.valid    = draw_fire;
      stage0_in.pos      = '0;
      stage0_in.thresh   = product[PROD_BITS-1:R_BITS];
      stage0_in.count    = count_ff;
      stage0_in.empty    = (count_ff == '0);
      stage0_in.fallback = (count_ff != '0) && (total_ff == '0);
   end

   assign chain[0] = stage0_ff;

   for (genvar k = 0; k < LEVELS; k++) begin : g_cell
      localparam int LVL = INDEX_BITS - 1 - k;
      localparam int AW  = (k > 0) ? k : 1;
      logic [INDEX_BITS-1:0] wr_addr_full;

      assign wr_addr_full = wr_index >> (LVL + 1);

      wrr_ram #(
         .ADDR_BITS (AW),
         .DATA_BITS (SUM_BITS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en && (wr_level == LEVEL_BITS'(LVL))),
         .wr_addr (wr_addr_full[AW-1:0]),
         .wr_data (new_total),
         .rd_addr (rd_addr[k][AW-1:0]),
         .rd_data (rd_data[k])
      );

      wrr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .level     (LEVEL_BITS'(LVL)),
         .up        (chain[k]),
         .down      (chain[k+1]),
         .ram_addr  (rd_addr[k]),
         .ram_rdata (rd_data[k])
      );
   end

   // Chain exit: clamp to the last loaded particle, apply special cases
   always_comb begin
      last     = chain[LEVELS];
      arrive   = last.valid;
      count_m1 = last.count - COUNT_BITS'(1);
      result.uniform_fallback = last.fallback;
      result.empty_error      = last.empty;
      if (last.empty) begin
         result.chosen_index = '0;
      end else if (last.fallback) begin
         result.chosen_index = last.thresh[INDEX_BITS-1:0];
      end else if ({1'b0, last.pos} > count_m1) begin
         result.chosen_index = count_m1[INDEX_BITS-1:0];
      end else begin
         result.chosen_index = last.pos;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (draw_fire) begin
         busy_in = 1'b1;
      end else if (arrive) begin
         busy_in = 1'b0;
      end
   end

   // Two result slots: rsp register plus a skid behind it
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_fire) begin
         out_valid_in = 1'b0;
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end
      if (arrive) begin
         if (!out_valid_in) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff        <= '0;
         count_ff        <= '0;
         busy_ff         <= 1'b0;
         stage0_ff.valid <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         total_ff      <= total_in;
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         stage0_ff     <= stage0_in;
         out_ff        <= out_in;
         out_valid_ff  <= out_valid_in;
         skid_ff       <= skid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_arrive_busy: assert property (@(posedge clock) disable iff (reset)
      arrive |-> busy_ff)
      else $error("search result with no draw in flight");

   a_arrive_slot: assert property (@(posedge clock) disable iff (reset)
      arrive |-> !skid_valid_ff)
      else $error("search result with both result slots full");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full while rsp slot empty");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.empty_error && rsp_payload.uniform_fallback))
      else $error("empty and fallback flags together");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      load_fire |=> count_ff <= COUNT_BITS'(MAX_PARTICLES))
      else $error("weight count beyond capacity");

endmodule

>>> tb/weighted_roulette_resampler_top_tb.sv
`timescale 1ns / 1ps

module weighted_roulette_resampler_top_tb;
   import wrr_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 50;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Own copy of the wheel: prefix sums, total weight, particle count
   logic [SUM_BITS-1:0]   wheel_prefix [MAX_PARTICLES];
   logic [SUM_BITS-1:0]   wheel_total = '0;
   logic [COUNT_BITS-1:0] wheel_count = '0;

   rsp_type pending_picks [$];
   int      mismatches   = 0;
   int      send_pct     = 0;
   int      recv_pct     = 0;
   int      hold_left    = 0;
   int      quiet_cycles = 0;

   weighted_roulette_resampler_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one item to the wheel; returns 1 when it yields a pick
   function automatic bit roll_wheel(input req_type item, output rsp_type pick);
      logic [R_BITS+COUNT_BITS-1:0] scaled;
      logic [PROD_BITS-1:0]         prod;
      logic [SUM_BITS-1:0]          thresh;
      logic [INDEX_BITS-1:0]        idx;
      bit                           found;
      pick = '0;
      if (item.func == FUNC_LOAD) begin
         if (item.first) begin
            wheel_total = '0;
            wheel_count = '0;
         end
         if (wheel_count < MAX_PARTICLES) begin
            wheel_total = wheel_total + SUM_BITS'(item.value[WEIGHT_BITS-1:0]);
            wheel_prefix[wheel_count[INDEX_BITS-1:0]] = wheel_total;
            wheel_count = wheel_count + 1'b1;
         end
         return 1'b0;
      end
      if (wheel_count == 0) begin
         pick.empty_error = 1'b1;
      end else if (wheel_total == 0) begin
         scaled = item.value * wheel_count;
         pick.uniform_fallback = 1'b1;
         pick.chosen_index = scaled[R_BITS +: INDEX_BITS];
      end else begin
         prod   = item.value * wheel_total;
         thresh = prod[R_BITS +: SUM_BITS];
         idx    = INDEX_BITS'(wheel_count - 1'b1);
         found  = 1'b0;
         for (int i = 0; i < wheel_count; i++) begin
            if (!found && wheel_prefix[INDEX_BITS'(i)] > thresh) begin
               idx   = INDEX_BITS'(i);
               found = 1'b1;
            end
         end
         pick.chosen_index = idx;
      end
      return 1'b1;
   endfunction

   function automatic req_type make_req(input logic func, input logic [VALUE_BITS-1:0] value,
                                        input logic first);
      req_type item;
      item.func  = func;
      item.value = value;
      item.first = first;
      return item;
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_weight(input int mode);
      case (mode)
         0: return '0;
         1: return ($urandom_range(99) < 70) ? '0 : VALUE_BITS'($urandom);
         2: begin
            case ($urandom_range(2))
               0: return '0;
               1: return '1;
               default: return VALUE_BITS'(1);
            endcase
         end
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_fraction();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return VALUE_BITS'($urandom);
   endfunction

   task automatic send_item(input req_type item);
      rsp_type pick;
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      if (roll_wheel(item, pick)) pending_picks.push_back(pick);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_picks.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_draws();
      send_item(make_req(FUNC_DRAW, 16'h0000, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'hFFFF, 1'b1));
   endtask

   // Loads without first on an empty wheel append; zero total falls back to uniform
   task automatic test_unstarted_load();
      send_item(make_req(FUNC_LOAD, 16'h0000, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'h8000, 1'b0));
      send_item(make_req(FUNC_LOAD, 16'h0000, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'hFFFF, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'h8000, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'h7FFF, 1'b0));
   endtask

   task automatic test_weight_extremes();
      send_item(make_req(FUNC_LOAD, 16'hFFFF, 1'b1));
      send_item(make_req(FUNC_LOAD, 16'h0000, 1'b0));
      send_item(make_req(FUNC_LOAD, 16'hFFFF, 1'b0));
      send_item(make_req(FUNC_LOAD, 16'h0001, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'h0000, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'hFFFF, 1'b1));
      send_item(make_req(FUNC_DRAW, 16'h8000, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'h7FFF, 1'b0));
      // leading zero weights must be skipped
      send_item(make_req(FUNC_LOAD, 16'h0000, 1'b1));
      send_item(make_req(FUNC_LOAD, 16'h0000, 1'b0));
      send_item(make_req(FUNC_LOAD, 16'h0005, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'h0000, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'hFFFF, 1'b0));
      drain();
   endtask

   task automatic test_full_store();
      for (int i = 0; i < MAX_PARTICLES + 2; i++)
         send_item(make_req(FUNC_LOAD, 16'hFFFF, i == 0));
      send_item(make_req(FUNC_DRAW, 16'h0000, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'hFFFF, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'h8000, 1'b0));
      send_item(make_req(FUNC_DRAW, 16'h0001, 1'b0));
      // restart a full wheel
      send_item(make_req(FUNC_LOAD, 16'h0007, 1'b1));
      send_item(make_req(FUNC_DRAW, 16'hFFFF, 1'b0));
      drain();
   endtask

   // Hold the result side off while items keep coming, so the block backs up
   task automatic test_backpressure();
      send_pct  = 0;
      recv_pct  = 0;
      hold_left = HOLD_CYCLES;
      for (int i = 0; i < 8; i++)
         send_item(make_req(FUNC_LOAD, VALUE_BITS'($urandom), i == 0));
      for (int i = 0; i < 6; i++)
         send_item(make_req(FUNC_DRAW, random_fraction(), 1'b0));
      drain();
   endtask

   task automatic run_random_phase(input int n_items, input int s_pct, input int r_pct);
      int      sent;
      int      set_size;
      int      mode;
      int      n_draws;
      int      roll;
      req_type item;
      send_pct = s_pct;
      recv_pct = r_pct;
      sent     = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 85) begin
            roll = $urandom_range(99);
            if (roll < 80) set_size = $urandom_range(1, 16);
            else if (roll < 97) set_size = $urandom_range(17, 200);
            else set_size = $urandom_range(500, 1100);
            // keep the phase close to its item budget
            if (set_size > n_items - sent) set_size = n_items - sent;
            mode = $urandom_range(3);
            for (int i = 0; i < set_size; i++) begin
               // now and then append to the previous set instead of restarting
               item = make_req(FUNC_LOAD, random_weight(mode),
                               i == 0 && $urandom_range(9) != 0);
               send_item(item);
            end
            n_draws = $urandom_range(1, 6);
            for (int i = 0; i < n_draws; i++) begin
               item = make_req(FUNC_DRAW, random_fraction(), 1'($urandom));
               send_item(item);
            end
            sent += set_size + n_draws;
         end else begin
            item = req_type'($bits(req_type)'($urandom));
            send_item(item);
            sent++;
         end
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_pct);
      end
   end

   always @(posedge clock) begin : check_picks
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_picks.size() == 0) begin
            $display("%0t: result with none expected: expected none, got %p",
                     $time, rsp_payload);
            mismatches++;
         end else begin
            want = pending_picks.pop_front();
            if (rsp_payload.chosen_index !== want.chosen_index) begin
               $display("%0t: chosen_index expected %0d, got %0d",
                        $time, want.chosen_index, rsp_payload.chosen_index);
               mismatches++;
            end
            if (rsp_payload.uniform_fallback !== want.uniform_fallback) begin
               $display("%0t: uniform_fallback expected %0b, got %0b",
                        $time, want.uniform_fallback, rsp_payload.uniform_fallback);
               mismatches++;
            end
            if (rsp_payload.empty_error !== want.empty_error) begin
               $display("%0t: empty_error expected %0b, got %0b",
                        $time, want.empty_error, rsp_payload.empty_error);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_draws();
      test_unstarted_load();
      test_weight_extremes();
      test_full_store();
      test_backpressure();
      run_random_phase(50, 0, 0);
      run_random_phase(45, 68, 0);
      run_random_phase(45, 0, 68);
      run_random_phase(45, 21, 21);
      send_pct = 0;
      recv_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_picks.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/wrr_pkg.sv
hdl/wrr_ram.sv
hdl/wrr_cell.sv
hdl/weighted_roulette_resampler_top.sv
tb/weighted_roulette_resampler_top_tb.sv
